// File: rtl/rbpt_pkg.sv
// ----------------------------------------------------------------------------
// Radial beam polynomial taper: shared package
// Widths, register codes and the flag bundle that rides along the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rbpt_pkg;

    // Field widths
    localparam int IDX_W    = 13;   // sample index
    localparam int ISQ_W    = 26;   // index squared
    localparam int U_W      = 32;   // squared radius, Q0.32
    localparam int COEF_W   = 48;   // coefficient, signed Q8.40
    localparam int SUM_W    = 52;   // polynomial sum, signed
    localparam int S_W      = 51;   // magnitude of a nonnegative sum
    localparam int TAPER_W  = 40;   // taper, Q16.24
    localparam int RAD_W    = 80;   // square root radicand
    localparam int ROOT_W   = 40;   // square root result
    localparam int SQREM_W  = 42;   // square root remainder

    // Stream widths (tdata padded to whole bytes)
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    // Configuration port
    localparam int APB_AW = 6;
    localparam int APB_DW = 64;
    localparam int NUM_COEF_REGS = 6;

    // Step counts of the iterative chains
    localparam int IDIV_STEPS = 89;  // quotient bits of 2^88 / S
    localparam int SQRT_STEPS = 40;  // root bits of an 80-bit radicand

    // Largest sum whose inverse root no longer fits the output
    localparam logic [S_W-1:0] INV_SAT_LIMIT = S_W'(256);

    // Register codes (index = paddr / 8)
    localparam logic [2:0] REG_NUM_COEFS = 3'd6;
    localparam logic [2:0] REG_INVERT    = 3'd7;

    // Per-word flags carried after the sum is known
    typedef struct packed {
        logic neg;     // sum below zero
        logic inv;     // inverse root of a nonzero sum
        logic ovr;     // inverse root out of range
    } t_flags;

endpackage

`default_nettype wire

// File: rtl/radial_beam_polynomial_taper.sv
// ----------------------------------------------------------------------------
// Radial beam polynomial taper
// Squared radius, polynomial sum, then square root or inverse square root.
//
//  channel   direction  handshake          payload
//  s stream  in         tvalid / tready    tdata[12:0] sample_index
//  m stream  out        tvalid / tready    tdata[39:0] taper,
//                                          tuser[0] clamped_negative,
//                                          tuser[1] saturated
//  apb       in         psel/penable/pwrite register i at paddr 8*i
//
//  One word enters per cycle while the input is not stalled; each word passes
//  the reciprocal multiply for the radius, the term cells, the 89-cell
//  inverse divider and 40 root cells.
//  Reset is synchronous, active low; coefficients clear, num_coefs = 1.
//  A result that is not taken parks in a skid stage; the input stalls
//  only once that stage is full, and then the whole chain holds.
// ----------------------------------------------------------------------------
`default_nettype none

module radial_beam_polynomial_taper #(
    parameter int SAMPLES   = 8192,
    parameter int MAX_COEFS = 6
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input stream
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [rbpt_pkg::S_TDATA_W-1:0] i_s_tdata,  // [12:0] sample_index
    // output stream
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic      [rbpt_pkg::M_TDATA_W-1:0] o_m_tdata,  // [39:0] taper
    output logic      [rbpt_pkg::M_TUSER_W-1:0] o_m_tuser,  // [0] clamped, [1] saturated
    // configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [rbpt_pkg::APB_AW-1:0]    paddr,
    input  wire logic [rbpt_pkg::APB_DW-1:0]    pwdata,
    output logic      [rbpt_pkg::APB_DW-1:0]    prdata,
    output logic                                pready
);
    import rbpt_pkg::*;

    localparam logic [63:0] D64 = 64'(SAMPLES - 1);
    localparam logic [16:0] DMAX = 17'(SAMPLES - 1);
    localparam logic [U_W-1:0] D2 = U_W'(D64 * D64);
    localparam int FW = $bits(t_flags);

    // Reciprocal of D^2: floor(isq * RM / 2^RK) equals floor(isq * 2^32 / D^2)
    // for every isq below 2^ISQ_W, since 2^RK >= D^2 * 2^ISQ_W
    localparam int RK = $clog2(D2) + ISQ_W;
    localparam logic [127:0] RM = ((128'd1 << (U_W + RK)) + 128'(D2) - 128'd1)
                                  / 128'(D2);
    localparam logic [29:0] RM_LO = RM[29:0];
    localparam logic [29:0] RM_HI = RM[59:30];

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COEF_W-1:0] r_coef [NUM_COEF_REGS];
    logic [2:0]        r_num_coefs;
    logic              r_invert;
    logic              w_wr;
    logic [2:0]        w_ridx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_ridx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COEF_REGS; k++) begin
                r_coef[k] <= '0;
            end
            r_num_coefs <= 3'd1;
            r_invert    <= 1'b0;
        end else if (w_wr) begin
            if (w_ridx == REG_NUM_COEFS) begin
                r_num_coefs <= pwdata[2:0];
            end else if (w_ridx == REG_INVERT) begin
                r_invert <= pwdata[0];
            end else begin
                r_coef[w_ridx] <= pwdata[COEF_W-1:0];
            end
        end
    end

    // Read back, coefficients sign extended
    always_comb begin
        case (w_ridx)
            REG_NUM_COEFS: prdata = {{(APB_DW-3){1'b0}}, r_num_coefs};
            REG_INVERT:    prdata = {{(APB_DW-1){1'b0}}, r_invert};
            default:       prdata = {{(APB_DW-COEF_W){r_coef[w_ridx][COEF_W-1]}},
                                     r_coef[w_ridx]};
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control: the chain moves unless the skid stage is occupied
    // ------------------------------------------------------------------
    logic w_en;
    logic r_skid_valid;

    assign w_en       = !r_skid_valid;
    assign o_s_tready = w_en;

    // ------------------------------------------------------------------
    // Input stage: clamp the index and square it
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] w_idx;
    logic [ISQ_W-1:0] w_isq;
    logic             r_in_valid;
    logic [ISQ_W-1:0] r_isq;
    logic             r_full;

    assign w_idx = ({4'b0, i_s_tdata[IDX_W-1:0]} > DMAX) ? DMAX[IDX_W-1:0]
                                                         : i_s_tdata[IDX_W-1:0];
    assign w_isq = w_idx * w_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_en) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_isq  <= w_isq;
            r_full <= ({4'b0, w_idx} == DMAX);
        end
    end

    // ------------------------------------------------------------------
    // Squared radius: isq * 2^32 / D^2 as a split reciprocal product
    // ------------------------------------------------------------------
    logic        r_r_valid;
    logic [55:0] r_r_ph;
    logic [55:0] r_r_pl;
    logic        r_r_full;
    logic [87:0] w_rt;
    logic [U_W-1:0] w_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
        end else if (w_en) begin
            r_r_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r_ph   <= r_isq * RM_HI;
            r_r_pl   <= r_isq * RM_LO;
            r_r_full <= r_full;
        end
    end

    // Join the halves and drop the fraction
    assign w_rt = {2'b0, r_r_ph, 30'b0} + {32'b0, r_r_pl};
    assign w_u  = U_W'(w_rt >> RK);

    // ------------------------------------------------------------------
    // Polynomial: constant term, then one term cell per higher power
    // ------------------------------------------------------------------
    logic             w_pv   [MAX_COEFS];
    logic [U_W-1:0]   w_pu   [MAX_COEFS];
    logic [U_W-1:0]   w_py   [MAX_COEFS];
    logic [SUM_W-1:0] w_ps   [MAX_COEFS];
    logic             r_p0_valid;
    logic [U_W-1:0]   r_p0_u;
    logic [SUM_W-1:0] r_p0_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_valid <= 1'b0;
        end else if (w_en) begin
            r_p0_valid <= r_r_valid;
        end
    end

    // Unit radius saturates u; the constant term enters as is unless num_coefs is zero
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p0_u   <= r_r_full ? '1 : w_u;
            r_p0_sum <= (r_num_coefs != 3'd0)
                      ? {{(SUM_W-COEF_W){r_coef[0][COEF_W-1]}}, r_coef[0]} : '0;
        end
    end

    assign w_pv[0] = r_p0_valid;
    assign w_pu[0] = r_p0_u;
    assign w_py[0] = r_p0_u;
    assign w_ps[0] = r_p0_sum;

    for (genvar j = 1; j < MAX_COEFS; j++) begin : g_term
        rbpt_term_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_pv[j-1]),
            .i_coef  (r_coef[j]),
            .i_use   (r_num_coefs > 3'(j)),
            .i_u     (w_pu[j-1]),
            .i_y     (w_py[j-1]),
            .i_sum   (w_ps[j-1]),
            .o_valid (w_pv[j]),
            .o_u     (w_pu[j]),
            .o_y     (w_py[j]),
            .o_sum   (w_ps[j])
        );
    end

    // ------------------------------------------------------------------
    // Classify the sum
    // ------------------------------------------------------------------
    logic             w_neg;
    logic             w_inv;
    logic             r_f_valid;
    logic [S_W-1:0]   r_f_s;
    t_flags           r_f_flags;

    assign w_neg = w_ps[MAX_COEFS-1][SUM_W-1];
    assign w_inv = r_invert && !w_neg && (w_ps[MAX_COEFS-1] != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (w_en) begin
            r_f_valid <= w_pv[MAX_COEFS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_s         <= w_ps[MAX_COEFS-1][S_W-1:0];
            r_f_flags.neg <= w_neg;
            r_f_flags.inv <= w_inv;
            r_f_flags.ovr <= w_inv && (w_ps[MAX_COEFS-1][S_W-1:0] <= INV_SAT_LIMIT);
        end
    end

    // ------------------------------------------------------------------
    // Inverse path: 2^88 / S, one quotient bit per cell
    // ------------------------------------------------------------------
    logic             w_id_v   [IDIV_STEPS+1];
    logic [S_W-1:0]   w_id_rem [IDIV_STEPS+1];
    logic [S_W-1:0]   w_id_div [IDIV_STEPS+1];
    logic [RAD_W-1:0] w_id_quo [IDIV_STEPS+1];
    logic [FW-1:0]    w_id_fl  [IDIV_STEPS+1];

    assign w_id_v[0]   = r_f_valid;
    assign w_id_rem[0] = '0;
    assign w_id_div[0] = r_f_s;
    assign w_id_quo[0] = '0;
    assign w_id_fl[0]  = r_f_flags;

    for (genvar k = 0; k < IDIV_STEPS; k++) begin : g_idiv
        rbpt_div_cell #(.RW(S_W), .QW(RAD_W), .PW(FW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_id_v[k]),
            .i_rem   (w_id_rem[k]),
            .i_div   (w_id_div[k]),
            .i_din   ((k == 0) ? 1'b1 : 1'b0),
            .i_quo   (w_id_quo[k]),
            .i_side  (w_id_fl[k]),
            .o_valid (w_id_v[k+1]),
            .o_rem   (w_id_rem[k+1]),
            .o_div   (w_id_div[k+1]),
            .o_quo   (w_id_quo[k+1]),
            .o_side  (w_id_fl[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Square root of the quotient or of S * 2^8
    // ------------------------------------------------------------------
    t_flags             w_dfl;
    logic               w_sq_v    [SQRT_STEPS+1];
    logic [RAD_W-1:0]   w_sq_rad  [SQRT_STEPS+1];
    logic [SQREM_W-1:0] w_sq_rem  [SQRT_STEPS+1];
    logic [ROOT_W-1:0]  w_sq_root [SQRT_STEPS+1];
    logic [FW-1:0]      w_sq_fl   [SQRT_STEPS+1];

    assign w_dfl        = t_flags'(w_id_fl[IDIV_STEPS]);
    assign w_sq_v[0]    = w_id_v[IDIV_STEPS];
    assign w_sq_rad[0]  = w_dfl.inv ? w_id_quo[IDIV_STEPS]
                        : {{(RAD_W-S_W-8){1'b0}}, w_id_div[IDIV_STEPS], 8'b0};
    assign w_sq_rem[0]  = '0;
    assign w_sq_root[0] = '0;
    assign w_sq_fl[0]   = w_id_fl[IDIV_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        rbpt_sqrt_cell #(.PW(FW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sq_v[k]),
            .i_rad   (w_sq_rad[k]),
            .i_rem   (w_sq_rem[k]),
            .i_root  (w_sq_root[k]),
            .i_side  (w_sq_fl[k]),
            .o_valid (w_sq_v[k+1]),
            .o_rad   (w_sq_rad[k+1]),
            .o_rem   (w_sq_rem[k+1]),
            .o_root  (w_sq_root[k+1]),
            .o_side  (w_sq_fl[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Final word: clamp, saturate, then output register and skid stage
    // ------------------------------------------------------------------
    t_flags             w_efl;
    logic               w_end_v;
    logic [TAPER_W-1:0] w_taper;
    logic               r_out_valid;
    logic [TAPER_W-1:0] r_out_taper;
    logic               r_out_clamp;
    logic               r_out_sat;
    logic [TAPER_W-1:0] r_skid_taper;
    logic               r_skid_clamp;
    logic               r_skid_sat;
    logic               w_take;

    assign w_efl   = t_flags'(w_sq_fl[SQRT_STEPS]);
    assign w_end_v = w_sq_v[SQRT_STEPS];
    assign w_taper = w_efl.neg ? '0 : (w_efl.ovr ? '1 : w_sq_root[SQRT_STEPS]);
    assign w_take  = r_out_valid && i_m_tready;

    // Hold control of output and skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || w_take) begin
            r_out_valid <= w_end_v;
        end else if (w_end_v) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Move payload into the output or park it
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out_taper <= r_skid_taper;
                r_out_clamp <= r_skid_clamp;
                r_out_sat   <= r_skid_sat;
            end
        end else if (!r_out_valid || w_take) begin
            r_out_taper <= w_taper;
            r_out_clamp <= w_efl.neg;
            r_out_sat   <= w_efl.ovr;
        end else begin
            r_skid_taper <= w_taper;
            r_skid_clamp <= w_efl.neg;
            r_skid_sat   <= w_efl.ovr;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_taper;
    assign o_m_tuser  = {r_out_sat, r_out_clamp};

endmodule

`default_nettype wire

// File: rtl/rbpt_div_cell.sv
// ----------------------------------------------------------------------------
// Restoring division cell
// Produces one quotient bit per cycle while enabled and hands remainder, divisor,
// partial quotient and side bits to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rbpt_div_cell #(
    parameter int RW = 32,
    parameter int QW = 32,
    parameter int PW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [RW-1:0] i_rem,
    input  wire logic [RW-1:0] i_div,
    input  wire logic          i_din,
    input  wire logic [QW-1:0] i_quo,
    input  wire logic [PW-1:0] i_side,
    output logic               o_valid,
    output logic      [RW-1:0] o_rem,
    output logic      [RW-1:0] o_div,
    output logic      [QW-1:0] o_quo,
    output logic      [PW-1:0] o_side
);

    logic [RW:0]   w_ext;
    logic [RW:0]   w_dext;
    logic          w_ge;
    logic [RW-1:0] n_rem;

    // Bring in the next dividend bit and try the subtraction
    assign w_ext  = {i_rem, i_din};
    assign w_dext = {1'b0, i_div};
    assign w_ge   = (w_ext >= w_dext);
    assign n_rem  = w_ge ? RW'(w_ext - w_dext) : w_ext[RW-1:0];

    // Clear valid under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    // Advance the payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= n_rem;
            o_div  <= i_div;
            o_quo  <= {i_quo[QW-2:0], w_ge};
            o_side <= i_side;
        end
    end

endmodule

`default_nettype wire

// File: rtl/rbpt_term_cell.sv
// ----------------------------------------------------------------------------
// Polynomial term cell
// Adds c_j * u^j to the running sum when the term is in use and forms the next power of u.
// Two register stages: products, then scale and accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module rbpt_term_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic [rbpt_pkg::COEF_W-1:0] i_coef,
    input  wire logic                        i_use,
    input  wire logic [rbpt_pkg::U_W-1:0]    i_u,
    input  wire logic [rbpt_pkg::U_W-1:0]    i_y,
    input  wire logic [rbpt_pkg::SUM_W-1:0]  i_sum,
    output logic                             o_valid,
    output logic      [rbpt_pkg::U_W-1:0]    o_u,
    output logic      [rbpt_pkg::U_W-1:0]    o_y,
    output logic      [rbpt_pkg::SUM_W-1:0]  o_sum
);
    import rbpt_pkg::*;

    logic              w_neg;
    logic [COEF_W-1:0] w_mag;
    logic              r_a_valid;
    logic [55:0]       r_a_ph;
    logic [55:0]       r_a_pl;
    logic [63:0]       r_a_yu;
    logic [U_W-1:0]    r_a_u;
    logic [SUM_W-1:0]  r_a_sum;
    logic [56:0]       w_acc;
    logic [48:0]       w_q;
    logic [SUM_W-1:0]  w_qx;
    logic [SUM_W-1:0]  n_sum;

    // Sign and magnitude of the coefficient (the most negative code maps to 2^47)
    assign w_neg = i_coef[COEF_W-1];
    assign w_mag = w_neg ? (~i_coef + COEF_W'(1)) : i_coef;

    // Stage A: split products and next power
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_ph  <= w_mag[47:24] * i_y;
            r_a_pl  <= w_mag[23:0] * i_y;
            r_a_yu  <= i_y * i_u;
            r_a_u   <= i_u;
            r_a_sum <= i_sum;
        end
    end

    // Stage B: floor(mag * y / 2^32), signed add
    assign w_acc = {1'b0, r_a_ph} + {25'b0, r_a_pl[55:24]};
    assign w_q   = w_acc[56:8];
    assign w_qx  = {{(SUM_W-49){1'b0}}, w_q};

    always_comb begin
        if (!i_use) begin
            n_sum = r_a_sum;
        end else if (w_neg) begin
            n_sum = r_a_sum - w_qx;
        end else begin
            n_sum = r_a_sum + w_qx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_u   <= r_a_u;
            o_y   <= r_a_yu[63:32];
            o_sum <= n_sum;
        end
    end

endmodule

`default_nettype wire

// File: rtl/rbpt_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Integer square root cell
// Consumes two radicand bits and yields one root bit per cycle while enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module rbpt_sqrt_cell #(
    parameter int PW = 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic [rbpt_pkg::RAD_W-1:0]   i_rad,
    input  wire logic [rbpt_pkg::SQREM_W-1:0] i_rem,
    input  wire logic [rbpt_pkg::ROOT_W-1:0]  i_root,
    input  wire logic [PW-1:0]                i_side,
    output logic                              o_valid,
    output logic      [rbpt_pkg::RAD_W-1:0]   o_rad,
    output logic      [rbpt_pkg::SQREM_W-1:0] o_rem,
    output logic      [rbpt_pkg::ROOT_W-1:0]  o_root,
    output logic      [PW-1:0]                o_side
);
    import rbpt_pkg::*;

    logic [SQREM_W+1:0] w_ext;
    logic [SQREM_W+1:0] w_trial;
    logic               w_ge;
    logic [SQREM_W-1:0] n_rem;

    // Shift in the next bit pair and compare against 4*root+1
    assign w_ext   = {i_rem, i_rad[RAD_W-1:RAD_W-2]};
    assign w_trial = {2'b00, i_root, 2'b01};
    assign w_ge    = (w_ext >= w_trial);
    assign n_rem   = w_ge ? SQREM_W'(w_ext - w_trial) : w_ext[SQREM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rad  <= {i_rad[RAD_W-3:0], 2'b00};
            o_rem  <= n_rem;
            o_root <= {i_root[ROOT_W-2:0], w_ge};
            o_side <= i_side;
        end
    end

endmodule

`default_nettype wire

// File: rtl/rbpt_checker.sv
// ----------------------------------------------------------------------------
// Radial beam polynomial taper: port checker
// Watches the top level's ports and flags inconsistent results.
// ----------------------------------------------------------------------------
`default_nettype none

module rbpt_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           o_s_tready,
    input wire logic                           o_m_tvalid,
    input wire logic                           i_m_tready,
    input wire logic [rbpt_pkg::M_TDATA_W-1:0] o_m_tdata,
    input wire logic [rbpt_pkg::M_TUSER_W-1:0] o_m_tuser
);

    // A stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                     && $stable(o_m_tuser))
        else $error("output word changed while stalled");

    // A clamped word is zero and not saturated
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> (o_m_tdata == '0) && !o_m_tuser[1])
        else $error("clamped word not zero");

    // A saturated word is full scale
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> (o_m_tdata == '1))
        else $error("saturated word not full scale");

    // Input stalls only behind a waiting output word
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with no output pending");

endmodule

bind radial_beam_polynomial_taper rbpt_checker u_rbpt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// Radial beam polynomial taper testbench
// Programs coefficient sets over the register port, streams sample indexes
// with random idling on both sides and checks every taper word against an
// in-bench model of the squared radius, polynomial sum and (inverse) root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import rbpt_pkg::*;

    localparam int LATENCY = 144;
    localparam logic [2:0] REG_COEF_ZERO = 3'd0;

    typedef struct packed {
        logic [TAPER_W-1:0] taper;
        logic               clamped;
        logic               sat;
    } t_taper;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_AW-1:0]     paddr = '0;
    logic [APB_DW-1:0]     pwdata = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    // Shadow copy of the registers
    logic [COEF_W-1:0] coef_shadow [NUM_COEF_REGS];
    logic [2:0]        ncoef_shadow = 3'd1;
    logic              invert_shadow = 1'b0;

    t_taper taper_queue [$];
    int     errors = 0;
    bit     calm = 1'b0;

    radial_beam_polynomial_taper uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata),   // [12:0] sample_index
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata),   // [39:0] taper
        .o_m_tuser(m_tuser),   // [0] clamped_negative, [1] saturated
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // floor(m * y / 2^32), y up to 2^32
    function automatic logic [63:0] mul_q32(logic [63:0] m, logic [63:0] y);
        logic [127:0] p;
        p = m * y;
        return p[95:32];
    endfunction

    function automatic logic [39:0] root80(logic [79:0] v);
        logic [81:0] rem;
        logic [41:0] root, trial;
        rem = '0;
        root = '0;
        for (int k = 39; k >= 0; k--) begin
            rem = (rem << 2) | v[2*k +: 2];
            trial = (root << 2) | 1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 1;
            end else begin
                root = root << 1;
            end
        end
        return root[39:0];
    endfunction

    function automatic logic [63:0] s_shift(logic signed [63:0] v);
        return v << 8;
    endfunction

    function automatic t_taper predict_taper(logic [12:0] idx);
        logic [63:0]        u, y, q, mag, s, isq;
        logic signed [63:0] sum;
        logic [127:0]       num;
        logic [95:0]        quo;
        int                 n;
        t_taper             r;
        isq = {51'd0, idx};
        isq = isq * isq;
        u = (isq << 32) / (64'd8191 * 64'd8191);
        if (u > 64'hFFFF_FFFF) u = 64'hFFFF_FFFF;
        n = (ncoef_shadow > 6) ? 6 : ncoef_shadow;
        y = 64'h1_0000_0000;
        sum = 0;
        for (int j = 0; j < n; j++) begin
            mag = coef_shadow[j][47] ? {16'd0, -coef_shadow[j]} : {16'd0, coef_shadow[j]};
            if (coef_shadow[j][47] && mag[47:0] == 0) mag = 64'h8000_0000_0000;
            q = mul_q32(mag, y);
            sum = coef_shadow[j][47] ? sum - $signed(q) : sum + $signed(q);
            y = mul_q32(y, u);
        end
        r = '0;
        if (sum < 0) begin
            r.clamped = 1'b1;
        end else if (invert_shadow && sum != 0) begin
            s = sum;
            if (s <= 256) begin
                r.sat = 1'b1;
                r.taper = '1;
            end else begin
                num = 128'd1 << 88;
                quo = num / s;
                r.taper = root80(quo[79:0]);
            end
        end else begin
            r.taper = root80({16'd0, s_shift(sum)});
        end
        return r;
    endfunction

    task automatic idle_cycles(int n);
        repeat (n) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 3'b000}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx < NUM_COEF_REGS) coef_shadow[idx] = val[47:0];
        else if (idx == REG_NUM_COEFS) ncoef_shadow = val[2:0];
        else invert_shadow = val[0];
    endtask

    // Drop valid, wait out every pending word, then the pipeline depth
    task automatic drain();
        s_tvalid <= 1'b0;
        while (taper_queue.size() != 0) @(negedge i_clk);
        idle_cycles(LATENCY + 8);
    endtask

    task automatic send_index(logic [12:0] idx);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            idle_cycles($urandom_range(1, 16));
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'd0, idx};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        taper_queue.push_back(predict_taper(idx));
        @(negedge i_clk);
    endtask

    function automatic logic [47:0] rand_coef();
        logic [47:0] c;
        c = 48'({$urandom(), $urandom()});
        case ($urandom_range(0, 4))
            0: c = {{10{c[47]}}, c[37:0]};
            1: c = 48'h8000_0000_0000;
            2: c = 48'h7FFF_FFFF_FFFF;
            default: c = {{6{c[47]}}, c[41:0]};
        endcase
        return c;
    endfunction

    task automatic load_set(logic [2:0] n, logic inv);
        for (int j = 0; j < NUM_COEF_REGS; j++) write_reg(REG_COEF_ZERO + 3'(j), rand_coef());
        write_reg(REG_NUM_COEFS, n);
        write_reg(REG_INVERT, inv);
    endtask

    // Check each accepted result word
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (taper_queue.size() == 0) begin
                $display("%0t unexpected word: expected none, actual %h/%b", $time,
                         m_tdata, m_tuser);
                errors++;
            end else begin
                t_taper e;
                e = taper_queue.pop_front();
                if (e.taper !== m_tdata || e.clamped !== m_tuser[0] || e.sat !== m_tuser[1]) begin
                    $display("%0t mismatch: expected %h c%b s%b, actual %h c%b s%b", $time,
                             e.taper, e.clamped, e.sat, m_tdata, m_tuser[0], m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    // Random receiver stalls
    initial begin
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                idle_cycles($urandom_range(1, 16) - 1);
                @(negedge i_clk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic test_reset_defaults();
        send_index(13'd0);
        send_index(13'd8191);
        drain();
    endtask

    task automatic test_directed_edges();
        // Unit constant term, square root over edge indexes
        write_reg(REG_COEF_ZERO, 48'h010000000000);
        write_reg(REG_NUM_COEFS, 3'd0);
        send_index(13'd100);  // empty sum
        drain();
        write_reg(REG_NUM_COEFS, 3'd7);  // count above the limit
        for (int j = 1; j < NUM_COEF_REGS; j++) write_reg(REG_COEF_ZERO + 3'(j), 48'hFF0000000000);
        send_index(13'd0); send_index(13'd1); send_index(13'd8191); send_index(13'd4096);
        drain();
        // Negative sum, extreme coefficients
        write_reg(REG_COEF_ZERO, 48'h800000000000);
        write_reg(REG_NUM_COEFS, 3'd1);
        send_index(13'd5);
        drain();
        write_reg(REG_COEF_ZERO, 48'h7FFFFFFFFFFF);
        send_index(13'd5);
        drain();
        // Inverse: large sum, sums at the saturation limit, tiny sum, zero sum, negative sum
        write_reg(REG_INVERT, 1'b1);
        send_index(13'd7);
        drain();
        write_reg(REG_COEF_ZERO, 48'd256);  send_index(13'd7); drain();
        write_reg(REG_COEF_ZERO, 48'd257);  send_index(13'd7); drain();
        write_reg(REG_COEF_ZERO, 48'd1);    send_index(13'd7); drain();
        write_reg(REG_COEF_ZERO, 48'd0);    send_index(13'd7); drain();
        write_reg(REG_COEF_ZERO, 48'h800000000000); send_index(13'd7); drain();
    endtask

    task automatic test_random_sets();
        for (int set = 0; set < 34; set++) begin
            load_set(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            if (set == 30) calm = 1'b1;
            for (int k = 0; k < 25; k++) begin
                if ($urandom_range(0, 9) == 0) send_index(13'($urandom_range(8190, 8191)));
                else send_index(13'($urandom_range(0, 8191)));
                if (k == 12 && set == 3) drain();  // sender waits for every word
            end
            drain();
        end
    endtask

    initial begin
        for (int j = 0; j < NUM_COEF_REGS; j++) coef_shadow[j] = '0;
        idle_cycles(10);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_directed_edges();
        test_random_sets();
        if (errors == 0 && taper_queue.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end
endmodule
